// File: hw/rtl/triangle_affine_transform_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the triangle affine transform unit
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_AFFINE_TRANSFORM_UNIT_ASSERT_SVH
`define TRIANGLE_AFFINE_TRANSFORM_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// File: hw/rtl/tatu_pkg.sv
// ----------------------------------------------------------------------------
// tatu_pkg
// Types, operation codes and saturation helper for the triangle transform.
// ----------------------------------------------------------------------------
package tatu_pkg;

  localparam int unsigned NUM_VERTICES = 3;
  localparam int unsigned ROT_SHIFT    = 14;
  localparam int unsigned SCALE_SHIFT  = 8;
  localparam int unsigned H_SHIFT      = 30;

  localparam logic signed [63:0] COORD_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] COORD_MIN = 64'shFFFF_FFFF_8000_0000;
  localparam logic signed [63:0] ROT_HALF   = 64'sd8192;
  localparam logic signed [63:0] SCALE_HALF = 64'sd128;

  localparam logic [45:0] SQRT3_HALF_Q30 = 46'd929887697;

  typedef enum logic [2:0] {
    OP_LOAD      = 3'd0,
    OP_TRANSLATE = 3'd1,
    OP_ROTATE    = 3'd2,
    OP_REFLECT_X = 3'd3,
    OP_REFLECT_Y = 3'd4,
    OP_SCALE     = 3'd5
  } op_e;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  typedef struct packed {
    op_e                operation;
    coord_t             shift_x;
    coord_t             shift_y;
    logic signed [15:0] cos_term;
    logic signed [15:0] sin_term;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] base_x;
    logic signed [15:0] base_y;
    logic [15:0]        side_length;
  } cmd_t;

  typedef struct packed {
    coord_t value;
    logic   clipped;
  } sat_t;

  typedef struct packed {
    vertex_t vtx;
    logic    clipped;
  } xform_t;

  function automatic sat_t sat_coord(logic signed [63:0] v);
    sat_t r;
    if (v > COORD_MAX) begin
      r.value   = COORD_MAX[31:0];
      r.clipped = 1'b1;
    end else if (v < COORD_MIN) begin
      r.value   = COORD_MIN[31:0];
      r.clipped = 1'b1;
    end else begin
      r.value   = v[31:0];
      r.clipped = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/tatu_load.sv
// ----------------------------------------------------------------------------
// tatu_load
// Builds an equilateral triangle from a base point and a side length.
// ----------------------------------------------------------------------------
module tatu_load
  import tatu_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  cmd_t                        cmd_i,
  output vertex_t [NUM_VERTICES-1:0]  vtx_o,
  output logic                        clipped_o
);

  localparam int unsigned HW = 46 + FRACTION_BITS;

  logic signed [63:0] x0_w;
  logic signed [63:0] y0_w;
  logic signed [63:0] len_w;
  logic [45:0]        prod_w;
  logic [HW-1:0]      hsh_w;
  logic [HW-1:0]      hsum_w;
  logic signed [63:0] h_w;
  sat_t               s0x, s0y, s1x, s2x, s2y;

  assign x0_w   = 64'(cmd_i.base_x) <<< FRACTION_BITS;
  assign y0_w   = 64'(cmd_i.base_y) <<< FRACTION_BITS;
  assign len_w  = signed'(64'(cmd_i.side_length)) <<< FRACTION_BITS;
  assign prod_w = 46'(cmd_i.side_length) * SQRT3_HALF_Q30;
  assign hsh_w  = HW'(prod_w) << FRACTION_BITS;
  assign hsum_w = hsh_w + (HW'(1) << (H_SHIFT - 1));
  assign h_w    = signed'(64'(hsum_w >> H_SHIFT));

  assign s0x = sat_coord(x0_w);
  assign s0y = sat_coord(y0_w);
  assign s1x = sat_coord(x0_w + len_w);
  assign s2x = sat_coord(x0_w + (len_w >>> 1));
  assign s2y = sat_coord(y0_w + h_w);

  assign vtx_o[0] = '{x: s0x.value, y: s0y.value};
  assign vtx_o[1] = '{x: s1x.value, y: s0y.value};
  assign vtx_o[2] = '{x: s2x.value, y: s2y.value};

  assign clipped_o = s0x.clipped | s0y.clipped | s1x.clipped | s2x.clipped | s2y.clipped;

endmodule

// File: hw/rtl/tatu_vertex.sv
// ----------------------------------------------------------------------------
// tatu_vertex
// Applies one translate, rotate, reflect or scale command to a vertex.
// ----------------------------------------------------------------------------
module tatu_vertex
  import tatu_pkg::*;
(
  input  cmd_t    cmd_i,
  input  vertex_t vtx_i,
  output xform_t  res_o
);

  logic signed [63:0] x_w, y_w;
  logic signed [47:0] xc_w, ys_w, xs_w, yc_w;
  logic signed [47:0] xsx_w, ysy_w;
  logic signed [63:0] nx_w, ny_w;
  sat_t               sx_w, sy_w;

  assign x_w = 64'(vtx_i.x);
  assign y_w = 64'(vtx_i.y);

  assign xc_w  = 48'(vtx_i.x) * 48'(cmd_i.cos_term);
  assign ys_w  = 48'(vtx_i.y) * 48'(cmd_i.sin_term);
  assign xs_w  = 48'(vtx_i.x) * 48'(cmd_i.sin_term);
  assign yc_w  = 48'(vtx_i.y) * 48'(cmd_i.cos_term);
  assign xsx_w = 48'(vtx_i.x) * 48'(cmd_i.scale_x);
  assign ysy_w = 48'(vtx_i.y) * 48'(cmd_i.scale_y);

  always_comb begin
    nx_w = x_w;
    ny_w = y_w;
    case (cmd_i.operation)
      OP_TRANSLATE: begin
        nx_w = x_w + 64'(cmd_i.shift_x);
        ny_w = y_w + 64'(cmd_i.shift_y);
      end
      OP_ROTATE: begin
        nx_w = (64'(xc_w) - 64'(ys_w) + ROT_HALF) >>> ROT_SHIFT;
        ny_w = (64'(xs_w) + 64'(yc_w) + ROT_HALF) >>> ROT_SHIFT;
      end
      OP_REFLECT_X: ny_w = -y_w;
      OP_REFLECT_Y: nx_w = -x_w;
      OP_SCALE: begin
        nx_w = (64'(xsx_w) + SCALE_HALF) >>> SCALE_SHIFT;
        ny_w = (64'(ysy_w) + SCALE_HALF) >>> SCALE_SHIFT;
      end
      default: begin
        nx_w = x_w;
        ny_w = y_w;
      end
    endcase
  end

  assign sx_w = sat_coord(nx_w);
  assign sy_w = sat_coord(ny_w);

  assign res_o.vtx     = '{x: sx_w.value, y: sy_w.value};
  assign res_o.clipped = sx_w.clipped | sy_w.clipped;

endmodule

// File: hw/rtl/triangle_affine_transform_unit.sv
// ----------------------------------------------------------------------------
// triangle_affine_transform_unit
// Path from input transfer to result valid: the input register, then the
//   vertex register that also serves as the result register.
// Throughput: 1 command per cycle unless stalled; feedback is registered.
// Reset: vertices and saturated flag clear to zero, both stages go empty.
// ----------------------------------------------------------------------------
`include "triangle_affine_transform_unit_assert.svh"

module triangle_affine_transform_unit
  import tatu_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         operation_i,
  input  logic signed [31:0] shift_x_i,
  input  logic signed [31:0] shift_y_i,
  input  logic signed [15:0] cos_term_i,
  input  logic signed [15:0] sin_term_i,
  input  logic signed [15:0] scale_x_i,
  input  logic signed [15:0] scale_y_i,
  input  logic signed [15:0] base_x_i,
  input  logic signed [15:0] base_y_i,
  input  logic [15:0]        side_length_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] first_x_o,
  output logic signed [31:0] first_y_o,
  output logic signed [31:0] second_x_o,
  output logic signed [31:0] second_y_o,
  output logic signed [31:0] third_x_o,
  output logic signed [31:0] third_y_o,
  output logic               saturated_o
);

  cmd_t                       cmd_q, cmd_d;
  logic                       cmd_valid_q;
  logic                       out_valid_q;
  vertex_t [NUM_VERTICES-1:0] vtx_q, vtx_d;
  logic                       sat_q, sat_d;
  vertex_t [NUM_VERTICES-1:0] load_vtx;
  logic                       load_clipped;
  xform_t  [NUM_VERTICES-1:0] xf_res;
  logic    [NUM_VERTICES-1:0] xf_clipped;
  logic                       advance;
  logic                       fire;
  logic                       in_take;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = cmd_valid_q && advance;
  assign in_stall_o = cmd_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_d.operation   = op_e'(operation_i);
    cmd_d.shift_x     = shift_x_i;
    cmd_d.shift_y     = shift_y_i;
    cmd_d.cos_term    = cos_term_i;
    cmd_d.sin_term    = sin_term_i;
    cmd_d.scale_x     = scale_x_i;
    cmd_d.scale_y     = scale_y_i;
    cmd_d.base_x      = base_x_i;
    cmd_d.base_y      = base_y_i;
    cmd_d.side_length = side_length_i;
  end

  tatu_load #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_load (
    .cmd_i    (cmd_q),
    .vtx_o    (load_vtx),
    .clipped_o(load_clipped)
  );

  for (genvar gi = 0; gi < NUM_VERTICES; gi++) begin : g_vertex
    tatu_vertex u_vertex (
      .cmd_i(cmd_q),
      .vtx_i(vtx_q[gi]),
      .res_o(xf_res[gi])
    );
    assign xf_clipped[gi] = xf_res[gi].clipped;
  end

  always_comb begin
    if (cmd_q.operation == OP_LOAD) begin
      vtx_d = load_vtx;
      sat_d = load_clipped;
    end else begin
      for (int i = 0; i < NUM_VERTICES; i++) begin
        vtx_d[i] = xf_res[i].vtx;
      end
      sat_d = |xf_clipped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      vtx_q       <= '0;
      sat_q       <= 1'b0;
    end else begin
      if (in_take) begin
        cmd_valid_q <= 1'b1;
      end else if (advance) begin
        cmd_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= cmd_valid_q;
      end
      if (fire) begin
        vtx_q <= vtx_d;
        sat_q <= sat_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q <= cmd_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign first_x_o   = vtx_q[0].x;
  assign first_y_o   = vtx_q[0].y;
  assign second_x_o  = vtx_q[1].x;
  assign second_y_o  = vtx_q[1].y;
  assign third_x_o   = vtx_q[2].x;
  assign third_y_o   = vtx_q[2].y;
  assign saturated_o = sat_q;

  `ASSERT_ALWAYS(a_stall_only_when_blocked, clk_i, in_stall_o |-> (out_valid_o && out_stall_i), "input stalled without a blocked result")
  `ASSERT_RST(a_fire_gives_result, clk_i, rst_ni, fire |=> out_valid_o, "transfer to result stage lost")
  `ASSERT_RST(a_state_holds, clk_i, rst_ni, !fire |=> $stable(vtx_q), "vertices changed without a command")
  `ASSERT_RST(a_unused_op_no_sat, clk_i, rst_ni, (fire && (cmd_q.operation > OP_SCALE)) |=> !saturated_o, "unused operation reported saturation")

endmodule
